// ----- rtl/ple_pkg.sv -----
package ple_pkg;

  localparam int PLE_CAPACITY = 64;
  localparam int VALUE_W      = 32;
  localparam int POS_W        = 8;
  localparam int COUNT_W      = 7;

  typedef enum logic [2:0] {
    CMD_INS_FRONT = 3'd0,
    CMD_INS_BACK  = 3'd1,
    CMD_DEL_FRONT = 3'd2,
    CMD_DEL_BACK  = 3'd3,
    CMD_INS_AT    = 3'd4,
    CMD_DEL_AT    = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_WSTART,
    S_WALK,
    S_ALLOC,
    S_ILINK1,
    S_ILINK2,
    S_DREAD,
    S_DLINK1,
    S_DLINK2,
    S_RESP
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic walk_start;
    logic walk_step;
    logic alloc_read;
    logic ins_link1;
    logic ins_link2;
    logic del_read;
    logic del_link1;
    logic del_link2;
    logic resp_load;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic dec_ok;
    logic dec_ins;
    logic dec_walk;
    logic op_ins;
    logic walk_last;
    logic out_free;
  } dp_stat_t;

endpackage

// ----- rtl/ple_ctrl.sv -----
module ple_ctrl import ple_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     cmd_valid,
  output logic     cmd_stall,
  input  dp_stat_t stat,
  output dp_cmd_t  ctl
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    cmd_stall  = 1'b1;
    case (state)
      S_IDLE: begin
        cmd_stall = 1'b0;
        if (cmd_valid) begin
          ctl.capture = 1'b1;
          if (!stat.dec_ok) begin
            state_next = S_RESP;
          end else if (stat.dec_walk) begin
            state_next = S_WSTART;
          end else if (stat.dec_ins) begin
            state_next = S_ALLOC;
          end else begin
            state_next = S_DREAD;
          end
        end
      end
      S_WSTART: begin
        ctl.walk_start = 1'b1;
        state_next     = S_WALK;
      end
      S_WALK: begin
        ctl.walk_step = 1'b1;
        if (stat.walk_last) begin
          state_next = stat.op_ins ? S_ALLOC : S_DREAD;
        end
      end
      S_ALLOC: begin
        ctl.alloc_read = 1'b1;
        state_next     = S_ILINK1;
      end
      S_ILINK1: begin
        ctl.ins_link1 = 1'b1;
        state_next    = S_ILINK2;
      end
      S_ILINK2: begin
        ctl.ins_link2 = 1'b1;
        state_next    = S_RESP;
      end
      S_DREAD: begin
        ctl.del_read = 1'b1;
        state_next   = S_DLINK1;
      end
      S_DLINK1: begin
        ctl.del_link1 = 1'b1;
        state_next    = S_DLINK2;
      end
      S_DLINK2: begin
        ctl.del_link2 = 1'b1;
        state_next    = S_RESP;
      end
      S_RESP: begin
        if (stat.out_free) begin
          ctl.resp_load = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/ple_datapath.sv -----
module ple_datapath import ple_pkg::*; #(
  parameter int CAPACITY = PLE_CAPACITY
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [2:0]                cmd,
  input  logic signed [VALUE_W-1:0] item_value,
  input  logic [POS_W-1:0]          position,
  input  dp_cmd_t                   ctl,
  output dp_stat_t                  stat,
  output logic                      res_valid,
  input  logic                      res_stall,
  output logic [1:0]                status,
  output logic [COUNT_W-1:0]        element_count
);

  localparam int SW   = $clog2(CAPACITY + 1);
  localparam int SIDX = $clog2(CAPACITY);
  localparam int PW   = ((SW > POS_W) ? SW : POS_W) + 1;
  localparam logic [SW-1:0] NIL = SW'(CAPACITY);

  logic [SW-1:0]      nxt_mem [CAPACITY];
  logic [SW-1:0]      prv_mem [CAPACITY];
  logic [VALUE_W-1:0] elem_mem [CAPACITY];

  logic [SW-1:0]      head, tail, free_head, fill, count;
  logic [SW-1:0]      cur, slot, pv;
  logic [POS_W-1:0]   rem;
  logic               op_ins;
  status_t            op_status;
  logic [VALUE_W-1:0] value_q;
  logic [SW-1:0]      nxt_q, prv_q;

  logic [SW-1:0]      nxt_raddr, nxt_waddr, nxt_wdata;
  logic [SW-1:0]      prv_waddr, prv_wdata;
  logic               nxt_we, prv_we, elem_we;
  logic [SW-1:0]      s_new, pv_new;
  logic               use_free;
  logic               link_re;

  // command decode
  status_t          dec_status;
  logic             dec_ins, dec_walk;
  logic [SW-1:0]    dec_cur;
  logic [PW-1:0]    pos_x, cnt_x;
  logic             full, empty;
  logic [31:0]      cnt32;

  always_comb begin
    pos_x      = PW'(position);
    cnt_x      = PW'(count);
    full       = (count == NIL);
    empty      = (count == '0);
    dec_status = ST_DONE;
    dec_ins    = 1'b0;
    dec_walk   = 1'b0;
    dec_cur    = head;
    case (cmd)
      CMD_INS_FRONT: begin
        dec_ins = 1'b1;
        if (full) dec_status = ST_FULL;
      end
      CMD_INS_BACK: begin
        dec_ins = 1'b1;
        dec_cur = NIL;
        if (full) dec_status = ST_FULL;
      end
      CMD_DEL_FRONT: begin
        if (empty) dec_status = ST_EMPTY;
      end
      CMD_DEL_BACK: begin
        dec_cur = tail;
        if (empty) dec_status = ST_EMPTY;
      end
      CMD_INS_AT: begin
        dec_ins = 1'b1;
        if (pos_x == '0 || pos_x > cnt_x + PW'(1)) begin
          dec_status = ST_RANGE;
        end else if (full) begin
          dec_status = ST_FULL;
        end
        // appending after the last element needs no walk
        if (pos_x == cnt_x + PW'(1)) begin
          dec_cur = NIL;
        end else begin
          dec_walk = (pos_x > PW'(1));
        end
      end
      CMD_DEL_AT: begin
        if (empty) begin
          dec_status = ST_EMPTY;
        end else if (pos_x == '0 || pos_x > cnt_x) begin
          dec_status = ST_RANGE;
        end
        dec_walk = (pos_x > PW'(1));
      end
      default: begin
        dec_status = ST_RANGE;
      end
    endcase
  end

  assign use_free = (free_head != NIL);
  assign s_new    = use_free ? free_head : fill;
  assign pv_new   = (cur != NIL) ? prv_q : tail;

  assign stat.dec_ok    = (dec_status == ST_DONE);
  assign stat.dec_ins   = dec_ins;
  assign stat.dec_walk  = dec_walk;
  assign stat.op_ins    = op_ins;
  assign stat.walk_last = (rem == POS_W'(1));
  assign stat.out_free  = !res_valid || !res_stall;

  // link reads only in the steps that need them, held otherwise
  assign link_re = ctl.walk_start || ctl.walk_step || ctl.alloc_read || ctl.del_read;

  // read addresses: walking chases the registered forward link directly
  always_comb begin
    if (ctl.walk_step) begin
      nxt_raddr = nxt_q;
    end else if (ctl.alloc_read) begin
      nxt_raddr = free_head;
    end else begin
      nxt_raddr = cur;
    end
  end

  // write ports
  always_comb begin
    nxt_we    = 1'b0;
    nxt_waddr = cur;
    nxt_wdata = cur;
    prv_we    = 1'b0;
    prv_waddr = cur;
    prv_wdata = cur;
    elem_we   = 1'b0;
    if (ctl.ins_link1) begin
      nxt_we    = 1'b1;
      nxt_waddr = s_new;
      nxt_wdata = cur;
      prv_we    = 1'b1;
      prv_waddr = s_new;
      prv_wdata = pv_new;
      elem_we   = 1'b1;
    end else if (ctl.ins_link2) begin
      nxt_we    = (pv != NIL);
      nxt_waddr = pv;
      nxt_wdata = slot;
      prv_we    = (cur != NIL);
      prv_waddr = cur;
      prv_wdata = slot;
    end else if (ctl.del_link1) begin
      nxt_we    = (prv_q != NIL);
      nxt_waddr = prv_q;
      nxt_wdata = nxt_q;
      prv_we    = (nxt_q != NIL);
      prv_waddr = nxt_q;
      prv_wdata = prv_q;
    end else if (ctl.del_link2) begin
      nxt_we    = 1'b1;
      nxt_waddr = cur;
      nxt_wdata = free_head;
    end
  end

  always_ff @(posedge clk) begin
    if (nxt_we) nxt_mem[nxt_waddr[SIDX-1:0]] <= nxt_wdata;
    if (prv_we) prv_mem[prv_waddr[SIDX-1:0]] <= prv_wdata;
    if (elem_we) elem_mem[s_new[SIDX-1:0]] <= value_q;
    if (link_re) begin
      nxt_q <= nxt_mem[nxt_raddr[SIDX-1:0]];
      prv_q <= prv_mem[cur[SIDX-1:0]];
    end
  end

  // list pointers and counts
  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= NIL;
      tail      <= NIL;
      free_head <= NIL;
      fill      <= '0;
      count     <= '0;
    end else begin
      if (ctl.ins_link1) begin
        // recycled slots first, then never-used ones
        if (use_free) begin
          free_head <= nxt_q;
        end else begin
          fill <= fill + SW'(1);
        end
      end
      if (ctl.ins_link2) begin
        if (pv == NIL) head <= slot;
        if (cur == NIL) tail <= slot;
        count <= count + SW'(1);
      end
      if (ctl.del_link1) begin
        if (prv_q == NIL) head <= nxt_q;
        if (nxt_q == NIL) tail <= prv_q;
      end
      if (ctl.del_link2) begin
        free_head <= cur;
        count     <= count - SW'(1);
      end
    end
  end

  // per-command working registers
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      op_status <= dec_status;
      op_ins    <= dec_ins;
      value_q   <= item_value;
      cur       <= dec_cur;
      rem       <= position - POS_W'(1);
    end
    if (ctl.walk_step) begin
      cur <= nxt_q;
      rem <= rem - POS_W'(1);
    end
    if (ctl.ins_link1) begin
      slot <= s_new;
      pv   <= pv_new;
    end
  end

  // result word
  assign cnt32 = 32'(count);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (ctl.resp_load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.resp_load) begin
      status        <= op_status;
      element_count <= cnt32[COUNT_W-1:0];
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= NIL && fill <= NIL)
    else $error("element count or fill beyond capacity");

  a_head_empty: assert property (@(posedge clk) disable iff (rst)
    ctl.resp_load |-> ((head == NIL) == (count == '0)))
    else $error("head link disagrees with element count");

  a_tail_empty: assert property (@(posedge clk) disable iff (rst)
    ctl.resp_load |-> ((tail == NIL) == (count == '0)))
    else $error("tail link disagrees with element count");

  a_walk_len: assert property (@(posedge clk) disable iff (rst)
    ctl.walk_step |-> (rem != '0 && cur != NIL))
    else $error("walk ran past its position");
`endif

endmodule

// ----- rtl/positional_list_engine_core.sv -----
// a rejected command goes straight to the response state, which waits until the output is free
// front or back insert or delete: allocate or read, then two link steps, then the response state
// positional commands above position one, other than an append, first walk the list, one link read per step
// a new command word is taken while the previous result word still waits
// synchronous reset empties the list at once; no memory clearing pass is needed
module positional_list_engine_core import ple_pkg::*; #(
  parameter int CAPACITY = PLE_CAPACITY
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cmd_valid,
  output logic                      cmd_stall,
  input  logic [2:0]                cmd,
  input  logic signed [VALUE_W-1:0] item_value,
  input  logic [POS_W-1:0]          position,
  output logic                      res_valid,
  input  logic                      res_stall,
  output logic [1:0]                status,
  output logic [COUNT_W-1:0]        element_count
);

  dp_cmd_t  ctl;
  dp_stat_t stat;

  ple_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .stat      (stat),
    .ctl       (ctl)
  );

  ple_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .item_value    (item_value),
    .position      (position),
    .ctl           (ctl),
    .stat          (stat),
    .res_valid     (res_valid),
    .res_stall     (res_stall),
    .status        (status),
    .element_count (element_count)
  );

endmodule
